FILE: rtl/rhsi_pkg.sv
// ----------------------------------------------------------------------------
// rhsi_pkg
// Shared types, constants and the cosine table for the rgb to hsi converter.
// ----------------------------------------------------------------------------
package rhsi_pkg;

    // table covers 0..180 degrees
    localparam int HUE_MAX_IDX = 180;
    localparam int COS_TAB_N   = HUE_MAX_IDX + 1;
    localparam int COS_W       = 18;

    // pipeline section lengths
    localparam int FRONT_STAGES = 4;
    localparam int SAT_Q_W      = 8;
    localparam int ROOT_W       = 17;
    localparam int C16_Q_W      = 18;
    localparam int SRCH_STEPS   = 8;

    // one degree rotation in q30
    localparam longint Q30_ONE  = 64'sd1073741824;
    localparam longint COS1_Q30 = 64'sd1073578288;
    localparam longint SIN1_Q30 = 64'sd18739379;

    // cosine ratio limit in q16
    localparam int C16_ONE = 65536;

    typedef logic signed [COS_W-1:0] cos_t;
    typedef logic [COS_TAB_N-1:0][COS_W-1:0] cos_tab_t;

    // payload carried through the saturation divider
    typedef struct packed {
        logic [16:0]       dd;
        logic signed [9:0] n2;
        logic              bgt;
        logic              undef;
        logic              blk;
        logic [7:0]        inten;
    } sat_side_t;

    // payload carried through the square root
    typedef struct packed {
        logic signed [9:0] n2;
        logic              bgt;
        logic              undef;
        logic [7:0]        inten;
        logic [7:0]        sat;
    } root_side_t;

    // payload kept to the end of the pipeline
    typedef struct packed {
        logic       bgt;
        logic       undef;
        logic [7:0] inten;
        logic [7:0] sat;
    } tail_t;

    // payload carried through the cosine divider
    typedef struct packed {
        logic  neg;
        tail_t tail;
    } quo_side_t;

    // cos(k deg) in q16, built by repeated one degree rotation in q30
    function automatic cos_tab_t build_cos_tab();
        longint   c;
        longint   s;
        longint   nc;
        longint   ns;
        cos_tab_t tab;
        c = Q30_ONE;
        s = 64'sd0;
        tab = '0;
        for (int k = 0; k < COS_TAB_N; k++)
        begin
            tab[k] = COS_W'((c + 64'sd8192) >>> 14);
            nc = (c * COS1_Q30 - s * SIN1_Q30 + 64'sd536870912) >>> 30;
            ns = (s * COS1_Q30 + c * SIN1_Q30 + 64'sd536870912) >>> 30;
            c = nc;
            s = ns;
        end
        return tab;
    endfunction

    localparam cos_tab_t COS_TAB = build_cos_tab();

    // table read, zero past the last entry
    function automatic cos_t cos_at(input logic [7:0] k);
        cos_t v;
        if (k <= 8'(HUE_MAX_IDX))
            v = cos_t'(COS_TAB[k]);
        else
            v = '0;
        return v;
    endfunction

endpackage

FILE: rtl/rhsi_div.sv
// ----------------------------------------------------------------------------
// rhsi_div
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// Needs num < den * 2**Q_W.
// ----------------------------------------------------------------------------
module rhsi_div #(
    parameter int NUM_W  = 18,
    parameter int DEN_W  = 10,
    parameter int Q_W    = 8,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [Q_W-1:0]    quot,
    output logic [SIDE_W-1:0] out_side
);

    localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic              vld_reg  [Q_W];
    logic [Q_W-1:0]    q_reg    [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];
    logic [W-1:0]      rem_reg  [Q_W-1];
    logic [DEN_W-1:0]  den_reg  [Q_W-1];

    for (genvar i = 0; i < Q_W; i++)
    begin : g_stage
        logic              vld_src;
        logic [W-1:0]      rem_src;
        logic [Q_W-1:0]    q_src;
        logic [DEN_W-1:0]  den_src;
        logic [SIDE_W-1:0] side_src;
        logic [W-1:0]      trial;
        logic              fits;

        // stage inputs
        if (i == 0)
        begin : g_first
            assign vld_src  = in_valid;
            assign rem_src  = W'(num);
            assign q_src    = '0;
            assign den_src  = den;
            assign side_src = in_side;
        end
        else
        begin : g_next
            assign vld_src  = vld_reg[i-1];
            assign rem_src  = rem_reg[i-1];
            assign q_src    = q_reg[i-1];
            assign den_src  = den_reg[i-1];
            assign side_src = side_reg[i-1];
        end

        // trial subtract for this quotient bit
        assign trial = W'(den_src) << (Q_W - 1 - i);
        assign fits  = (rem_src >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else
                vld_reg[i] <= vld_src;
        end

        always_ff @(posedge clk)
        begin
            q_reg[i]    <= fits ? (q_src | (Q_W'(1) << (Q_W - 1 - i))) : q_src;
            side_reg[i] <= side_src;
        end

        // remainder and divisor are not needed after the last bit
        if (i < Q_W - 1)
        begin : g_keep
            always_ff @(posedge clk)
            begin
                rem_reg[i] <= fits ? (rem_src - trial) : rem_src;
                den_reg[i] <= den_src;
            end
        end
    end

    assign out_valid = vld_reg[Q_W-1];
    assign quot      = q_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

FILE: rtl/rhsi_sqrt.sv
// ----------------------------------------------------------------------------
// rhsi_sqrt
// Pipelined integer square root, one root bit per stage, with side payload.
// ----------------------------------------------------------------------------
module rhsi_sqrt #(
    parameter int IN_W   = 33,
    parameter int RES_W  = 17,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [IN_W-1:0]   x,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [RES_W-1:0]  root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int W = 2 * RES_W + 1;

    logic              vld_reg  [RES_W];
    logic [W-1:0]      res_reg  [RES_W];
    logic [SIDE_W-1:0] side_reg [RES_W];
    logic [W-1:0]      x_reg    [RES_W-1];

    for (genvar i = 0; i < RES_W; i++)
    begin : g_stage
        logic              vld_src;
        logic [W-1:0]      x_src;
        logic [W-1:0]      res_src;
        logic [SIDE_W-1:0] side_src;
        logic [W-1:0]      trial;
        logic              fits;

        // stage inputs
        if (i == 0)
        begin : g_first
            assign vld_src  = in_valid;
            assign x_src    = W'(x);
            assign res_src  = '0;
            assign side_src = in_side;
        end
        else
        begin : g_next
            assign vld_src  = vld_reg[i-1];
            assign x_src    = x_reg[i-1];
            assign res_src  = res_reg[i-1];
            assign side_src = side_reg[i-1];
        end

        // test the next power of four
        assign trial = res_src + (W'(1) << (2 * (RES_W - 1 - i)));
        assign fits  = (x_src >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else
                vld_reg[i] <= vld_src;
        end

        always_ff @(posedge clk)
        begin
            res_reg[i]  <= fits ? ((res_src >> 1) + (W'(1) << (2 * (RES_W - 1 - i))))
                                : (res_src >> 1);
            side_reg[i] <= side_src;
        end

        if (i < RES_W - 1)
        begin : g_keep
            always_ff @(posedge clk)
            begin
                x_reg[i] <= fits ? (x_src - trial) : x_src;
            end
        end
    end

    assign out_valid = vld_reg[RES_W-1];
    assign root      = res_reg[RES_W-1][RES_W-1:0];
    assign out_side  = side_reg[RES_W-1];

endmodule

FILE: rtl/rgb_to_hsi_pixel_converter_top.sv
// ----------------------------------------------------------------------------
// rgb_to_hsi_pixel_converter_top
// Converts one 8-bit blue, green, red pixel to hue, saturation, intensity.
// ----------------------------------------------------------------------------
// Usage:
//   A pixel beat is taken at a rising edge with start high and busy low.
//   busy is always low, so a new pixel may be issued in every cycle.
//   Each result shows on hue_degrees, saturation, intensity and
//   hue_undefined for one cycle with done high, in issue order.
//   Throughput is one pixel per clock: every unit is a fully pipelined
//   chain, one quotient or root bit per stage in the saturation divider
//   (8 stages), the square root (17 stages) and the cosine divider
//   (18 stages), and one table compare per stage in the 8-step angle
//   search over the 181-entry cosine table.
//   Reset clears all valid bits; the pipeline holds no other state and
//   needs no warm-up.
//   The receiver cannot stall, so results leave as they are produced.
// ----------------------------------------------------------------------------
module rgb_to_hsi_pixel_converter_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [7:0] blue,
    input  logic [7:0] green,
    input  logic [7:0] red,
    output logic       busy,
    output logic       done,
    output logic [8:0] hue_degrees,
    output logic [7:0] saturation,
    output logic [7:0] intensity,
    output logic       hue_undefined
);

    import rhsi_pkg::*;

    localparam int LATENCY = FRONT_STAGES + SAT_Q_W + ROOT_W + C16_Q_W + 1
                           + SRCH_STEPS + 1;

    // never holds off a pixel
    assign busy = 1'b0;

    // stage 1: input capture
    logic       in_vld_reg;
    logic [7:0] b_reg, g_reg, r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        b_reg <= blue;
        g_reg <= green;
        r_reg <= red;
    end

    // stage 2: sum, minimum and differences
    logic              pre_vld_reg;
    logic [9:0]        sum_reg;
    logic [7:0]        mn_reg;
    logic signed [8:0] rg_reg, rb_reg, gb_reg;
    logic signed [9:0] n2_reg;
    logic              pre_bgt_reg;
    logic [7:0]        mn_next;

    always_comb
    begin
        mn_next = (r_reg < g_reg) ? r_reg : g_reg;
        if (b_reg < mn_next)
            mn_next = b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pre_vld_reg <= 1'b0;
        else
            pre_vld_reg <= in_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        sum_reg     <= 10'(b_reg) + 10'(g_reg) + 10'(r_reg);
        mn_reg      <= mn_next;
        rg_reg      <= $signed({1'b0, r_reg}) - $signed({1'b0, g_reg});
        rb_reg      <= $signed({1'b0, r_reg}) - $signed({1'b0, b_reg});
        gb_reg      <= $signed({1'b0, g_reg}) - $signed({1'b0, b_reg});
        n2_reg      <= $signed({1'b0, r_reg, 1'b0}) - $signed({2'b0, g_reg})
                     - $signed({2'b0, b_reg});
        pre_bgt_reg <= (b_reg > g_reg);
    end

    // stage 3: products
    logic              prod_vld_reg;
    logic signed [17:0] p1_reg, p2_reg;
    logic [17:0]       satnum_reg;
    logic [25:0]       iprod_reg;
    logic [9:0]        prod_sum_reg;
    logic signed [9:0] prod_n2_reg;
    logic              prod_bgt_reg;
    logic [9:0]        chroma;

    assign chroma = sum_reg - 10'(mn_reg) - 10'(mn_reg) - 10'(mn_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_vld_reg <= 1'b0;
        else
            prod_vld_reg <= pre_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        p1_reg       <= 18'(rg_reg) * 18'(rg_reg);
        p2_reg       <= 18'(rb_reg) * 18'(gb_reg);
        satnum_reg   <= (18'(chroma) << 8) - 18'(chroma);
        iprod_reg    <= 26'(sum_reg) * 26'd43691;
        prod_sum_reg <= sum_reg;
        prod_n2_reg  <= n2_reg;
        prod_bgt_reg <= pre_bgt_reg;
    end

    // stage 4: angle discriminant and intensity
    logic              mix_vld_reg;
    logic [17:0]       mix_satnum_reg;
    logic [9:0]        mix_sum_reg;
    sat_side_t         mix_side_reg;
    logic signed [18:0] dd_wide;

    assign dd_wide = 19'(p1_reg) + 19'(p2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mix_vld_reg <= 1'b0;
        else
            mix_vld_reg <= prod_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        mix_satnum_reg     <= satnum_reg;
        mix_sum_reg        <= prod_sum_reg;
        mix_side_reg.dd    <= dd_wide[16:0];
        mix_side_reg.n2    <= prod_n2_reg;
        mix_side_reg.bgt   <= prod_bgt_reg;
        mix_side_reg.undef <= (dd_wide == 19'sd0);
        mix_side_reg.blk   <= (prod_sum_reg == 10'd0);
        mix_side_reg.inten <= iprod_reg[24:17];
    end

    // saturation divider
    logic       sd_vld;
    logic [7:0] sd_quot;
    sat_side_t  sd_side;
    root_side_t rt_in_side;

    rhsi_div #(
        .NUM_W  (18),
        .DEN_W  (10),
        .Q_W    (SAT_Q_W),
        .SIDE_W ($bits(sat_side_t))
    ) u_sat_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mix_vld_reg),
        .num       (mix_satnum_reg),
        .den       (mix_sum_reg),
        .in_side   (mix_side_reg),
        .out_valid (sd_vld),
        .quot      (sd_quot),
        .out_side  (sd_side)
    );

    // black pixel gives zero saturation
    always_comb
    begin
        rt_in_side.n2    = sd_side.n2;
        rt_in_side.bgt   = sd_side.bgt;
        rt_in_side.undef = sd_side.undef;
        rt_in_side.inten = sd_side.inten;
        rt_in_side.sat   = sd_side.blk ? 8'd0 : sd_quot;
    end

    // denominator in q8
    logic              rt_vld;
    logic [ROOT_W-1:0] rt_root;
    root_side_t        rt_side;

    rhsi_sqrt #(
        .IN_W   (33),
        .RES_W  (ROOT_W),
        .SIDE_W ($bits(root_side_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sd_vld),
        .x         ({sd_side.dd, 16'd0}),
        .in_side   (rt_in_side),
        .out_valid (rt_vld),
        .root      (rt_root),
        .out_side  (rt_side)
    );

    // cosine ratio magnitude
    logic [9:0]   n2_abs;
    quo_side_t    cd_in_side;
    logic         cd_vld;
    logic [C16_Q_W-1:0] cd_quot;
    quo_side_t    cd_side;

    assign n2_abs = rt_side.n2[9] ? 10'(-rt_side.n2) : 10'(rt_side.n2);

    always_comb
    begin
        cd_in_side.neg        = rt_side.n2[9];
        cd_in_side.tail.bgt   = rt_side.bgt;
        cd_in_side.tail.undef = rt_side.undef;
        cd_in_side.tail.inten = rt_side.inten;
        cd_in_side.tail.sat   = rt_side.sat;
    end

    rhsi_div #(
        .NUM_W  (32),
        .DEN_W  (ROOT_W),
        .Q_W    (C16_Q_W),
        .SIDE_W ($bits(quo_side_t))
    ) u_cos_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rt_vld),
        .num       ({n2_abs[8:0], 23'd0}),
        .den       (rt_root),
        .in_side   (cd_in_side),
        .out_valid (cd_vld),
        .quot      (cd_quot),
        .out_side  (cd_side)
    );

    // signed and clamped cosine ratio
    logic               c16_vld_reg;
    cos_t               c16_reg;
    tail_t              c16_tail_reg;
    logic [C16_Q_W-1:0] c16_mag;

    assign c16_mag = (cd_quot > C16_Q_W'(C16_ONE)) ? C16_Q_W'(C16_ONE) : cd_quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c16_vld_reg <= 1'b0;
        else
            c16_vld_reg <= cd_vld;
    end

    always_ff @(posedge clk)
    begin
        c16_reg      <= cd_side.neg ? -cos_t'(c16_mag) : cos_t'(c16_mag);
        c16_tail_reg <= cd_side.tail;
    end

    // binary search for the largest angle whose cosine is still >= c16
    logic       sr_vld_reg  [SRCH_STEPS];
    logic [7:0] sr_idx_reg  [SRCH_STEPS];
    cos_t       sr_c16_reg  [SRCH_STEPS];
    tail_t      sr_tail_reg [SRCH_STEPS];

    for (genvar j = 0; j < SRCH_STEPS; j++)
    begin : g_srch
        logic       vld_src;
        logic [7:0] idx_src;
        cos_t       c16_src;
        tail_t      tail_src;
        logic [7:0] cand;
        logic       hit;

        if (j == 0)
        begin : g_first
            assign vld_src  = c16_vld_reg;
            assign idx_src  = 8'd0;
            assign c16_src  = c16_reg;
            assign tail_src = c16_tail_reg;
        end
        else
        begin : g_next
            assign vld_src  = sr_vld_reg[j-1];
            assign idx_src  = sr_idx_reg[j-1];
            assign c16_src  = sr_c16_reg[j-1];
            assign tail_src = sr_tail_reg[j-1];
        end

        assign cand = idx_src | (8'd1 << (SRCH_STEPS - 1 - j));
        assign hit  = (cand <= 8'(HUE_MAX_IDX)) && (cos_at(cand) >= c16_src);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sr_vld_reg[j] <= 1'b0;
            else
                sr_vld_reg[j] <= vld_src;
        end

        always_ff @(posedge clk)
        begin
            sr_idx_reg[j]  <= hit ? cand : idx_src;
            sr_c16_reg[j]  <= c16_src;
            sr_tail_reg[j] <= tail_src;
        end
    end

    // final hue: zero when undefined, else floor angle, or 360 minus ceiling angle when blue is above green
    logic       done_reg;
    logic [8:0] hue_reg;
    logic [7:0] sat_reg;
    logic [7:0] inten_reg;
    logic       undef_reg;
    logic [7:0] fl_idx;
    logic [7:0] ce_idx;
    tail_t      fin_tail;
    logic [8:0] hue_next;

    assign fl_idx   = sr_idx_reg[SRCH_STEPS-1];
    assign fin_tail = sr_tail_reg[SRCH_STEPS-1];

    always_comb
    begin
        if (cos_at(fl_idx) == sr_c16_reg[SRCH_STEPS-1])
            ce_idx = fl_idx;
        else if (fl_idx == 8'(HUE_MAX_IDX))
            ce_idx = fl_idx;
        else
            ce_idx = fl_idx + 8'd1;
        if (ce_idx == 8'd0)
            ce_idx = 8'd1;
        if (fin_tail.undef)
            hue_next = 9'd0;
        else if (fin_tail.bgt)
            hue_next = 9'd360 - 9'(ce_idx);
        else
            hue_next = 9'(fl_idx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= sr_vld_reg[SRCH_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        hue_reg   <= hue_next;
        sat_reg   <= fin_tail.sat;
        inten_reg <= fin_tail.inten;
        undef_reg <= fin_tail.undef;
    end

    assign done          = done_reg;
    assign hue_degrees   = hue_reg;
    assign saturation    = sat_reg;
    assign intensity     = inten_reg;
    assign hue_undefined = undef_reg;

    // every accepted pixel comes out after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result beat missing after fixed latency");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hue_degrees < 9'd360))
        else $error("hue out of range");

    a_gray: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hue_undefined) |-> (hue_degrees == 9'd0 && saturation == 8'd0))
        else $error("gray pixel with nonzero hue or saturation");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(sr_vld_reg[SRCH_STEPS-1]))
        else $error("result beat without a pixel in flight");

endmodule

FILE: tb/sv/rgb_to_hsi_pixel_converter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsi_pixel_converter_top_tb
// Drives pixels into the converter with random gaps and checks every
// hue, saturation, intensity and gray flag against a bit-exact predictor.
// ----------------------------------------------------------------------------
module rgb_to_hsi_pixel_converter_top_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 120;

    typedef struct {
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
        bit         drain_first;
    } pixel_t;

    typedef struct {
        logic [8:0] hue;
        logic [7:0] sat;
        logic [7:0] inten;
        logic       undef;
    } hsi_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       busy;
    logic       done;
    logic [8:0] hue_degrees;
    logic [7:0] saturation;
    logic [7:0] intensity;
    logic       hue_undefined;

    pixel_t pixel_q[$];
    hsi_t   hsi_q[$];
    longint cos_q16[0:180];
    int     err_cnt = 0;
    int     n_taken;
    int     n_seen;
    int     idle_cycles;
    int     gap_left;

    rgb_to_hsi_pixel_converter_top u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .blue(blue), .green(green),
        .red(red), .busy(busy), .done(done), .hue_degrees(hue_degrees),
        .saturation(saturation), .intensity(intensity),
        .hue_undefined(hue_undefined)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // cosine of whole degrees in q16 by repeated one degree rotation in q30
    task automatic fill_cos_table();
        longint c;
        longint s;
        longint nc;
        longint ns;
        c = 64'sd1073741824;
        s = 0;
        for (int k = 0; k <= 180; k++)
        begin
            cos_q16[k] = (c + 64'sd8192) >>> 14;
            nc = (c * 64'sd1073578288 - s * 64'sd18739379 + 64'sd536870912) >>> 30;
            ns = (s * 64'sd1073578288 + c * 64'sd18739379 + 64'sd536870912) >>> 30;
            c = nc;
            s = ns;
        end
    endtask

    function automatic longint int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    // expected hsi of one pixel
    function automatic hsi_t convert_pixel(logic [7:0] bb, logic [7:0] gg, logic [7:0] rr);
        hsi_t   o;
        longint b;
        longint g;
        longint r;
        longint sum;
        longint mn;
        longint dd;
        longint q;
        longint c16;
        int     tfloor;
        int     tceil;
        b = bb;
        g = gg;
        r = rr;
        sum = r + g + b;
        mn = (r < g) ? r : g;
        if (b < mn)
            mn = b;
        o.inten = 8'(sum / 3);
        o.sat = (sum > 0) ? 8'((255 * (sum - 3 * mn)) / sum) : 8'd0;
        o.hue = 9'd0;
        o.undef = 1'b0;
        dd = (r - g) * (r - g) + (r - b) * (g - b);
        if (dd <= 0)
            o.undef = 1'b1;
        else
        begin
            q = int_sqrt(longint'(dd) << 16);
            c16 = ((2 * r - g - b) * (64'sd1 << 23)) / q;
            if (c16 > 65536)
                c16 = 65536;
            if (c16 < -65536)
                c16 = -65536;
            tfloor = 0;
            tceil = -1;
            for (int k = 0; k <= 180; k++)
            begin
                if (cos_q16[k] >= c16)
                    tfloor = k;
                if (tceil < 0 && cos_q16[k] <= c16)
                    tceil = k;
            end
            if (tceil < 0)
                tceil = 180;
            if (b > g)
            begin
                // near-zero angle is held at one degree
                if (tceil < 1)
                    tceil = 1;
                o.hue = 9'(360 - tceil);
            end
            else
                o.hue = 9'(tfloor);
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    task automatic add_pixel(int b, int g, int r, bit drain);
        pixel_t p;
        p.b = 8'(b);
        p.g = 8'(g);
        p.r = 8'(r);
        p.drain_first = drain;
        pixel_q = {pixel_q, p};
    endtask

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(99);
        if (sel < 65)
            return 0;
        if (sel < 95)
            return $urandom_range(3, 1);
        return $urandom_range(60, 15);
    endfunction

    function automatic int pick_comp(int mode);
        if (mode == 0)
            return $urandom_range(255);
        return ($urandom_range(1) != 0) ? 255 - $urandom_range(2) : $urandom_range(2);
    endfunction

    // driver: one pixel beat per accepted start
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            blue <= 8'd0;
            green <= 8'd0;
            red <= 8'd0;
            gap_left <= 0;
        end
        else
        begin
            if (start && busy)
                start <= 1'b1;
            else if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pixel_q.size() == 0)
                start <= 1'b0;
            else if (pixel_q[0].drain_first && (start || n_taken != n_seen))
                start <= 1'b0;
            else
            begin
                blue <= pixel_q[0].b;
                green <= pixel_q[0].g;
                red <= pixel_q[0].r;
                start <= 1'b1;
                gap_left <= pick_gap();
                void'(pixel_q.pop_front());
            end
        end
    end

    // monitor: records taken pixels and checks each result beat
    always @(posedge clk or negedge rst_n)
    begin
        hsi_t want;
        if (!rst_n)
        begin
            n_taken <= 0;
            n_seen <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                hsi_q = {hsi_q, convert_pixel(blue, green, red)};
                n_taken <= n_taken + 1;
            end
            if (done)
            begin
                n_seen <= n_seen + 1;
                if (hsi_q.size() == 0)
                begin
                    $display("result beat with nothing pending at %0t", $realtime);
                    err_cnt++;
                end
                else
                begin
                    want = hsi_q.pop_front();
                    if (hue_degrees !== want.hue)
                        report_mismatch("hue", hue_degrees, want.hue);
                    if (saturation !== want.sat)
                        report_mismatch("saturation", saturation, want.sat);
                    if (intensity !== want.inten)
                        report_mismatch("intensity", intensity, want.inten);
                    if (hue_undefined !== want.undef)
                        report_mismatch("hue_undefined", hue_undefined, want.undef);
                end
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("rgb_to_hsi_pixel_converter_top_tb: errors");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin
        int mode;
        int base;
        fill_cos_table();
        rst_n = 1'b0;

        // directed corners
        add_pixel(0, 0, 0, 0);
        add_pixel(255, 255, 255, 0);
        add_pixel(128, 128, 128, 0);
        add_pixel(0, 0, 255, 0);
        add_pixel(0, 255, 0, 0);
        add_pixel(255, 0, 0, 0);
        add_pixel(255, 255, 0, 0);
        add_pixel(0, 255, 255, 0);
        add_pixel(255, 0, 255, 0);
        add_pixel(1, 0, 255, 0);
        add_pixel(0, 1, 255, 0);
        add_pixel(1, 0, 0, 0);
        add_pixel(0, 0, 1, 0);
        add_pixel(100, 100, 101, 0);
        add_pixel(101, 100, 100, 0);
        add_pixel(100, 101, 100, 0);
        add_pixel(254, 255, 255, 0);
        add_pixel(170, 85, 255, 0);
        add_pixel(85, 170, 0, 0);
        add_pixel(200, 10, 10, 0);
        add_pixel(10, 10, 200, 0);

        // random pixels, some near gray and some at the rails
        for (int i = 0; i < 1000; i++)
        begin
            mode = $urandom_range(9);
            if (mode < 6)
                add_pixel(pick_comp(0), pick_comp(0), pick_comp(0), i == 400 || i == 800);
            else if (mode < 8)
            begin
                base = $urandom_range(255);
                add_pixel(base ^ $urandom_range(3), base ^ $urandom_range(3),
                          base ^ $urandom_range(3), 0);
            end
            else
                add_pixel(pick_comp(1), pick_comp(1), pick_comp(1), 0);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // wait for the queue to empty and every result to come back
        @(posedge clk);
        while (!(pixel_q.size() == 0 && !start && n_taken == n_seen && hsi_q.size() == 0))
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_cnt == 0 && hsi_q.size() == 0)
            $display("rgb_to_hsi_pixel_converter_top_tb: clean");
        else
            $display("rgb_to_hsi_pixel_converter_top_tb: errors");
        $finish;
    end

endmodule

FILE: files.f
rtl/rhsi_pkg.sv
rtl/rhsi_div.sv
rtl/rhsi_sqrt.sv
rtl/rgb_to_hsi_pixel_converter_top.sv
tb/sv/rgb_to_hsi_pixel_converter_top_tb.sv
